@@ src/bucketed_sparse_tile_attribute_store_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef BUCKETED_SPARSE_TILE_ATTRIBUTE_STORE_MACROS_SVH
`define BUCKETED_SPARSE_TILE_ATTRIBUTE_STORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BST_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bst: implication violated");

// Next-cycle implication, disabled in reset.
`define BST_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bst: next-cycle implication violated");

`endif

@@ src/bst_pkg.sv @@
package bst_pkg;

  // Geometry
  localparam int BLOCK_SIDE      = 8;
  localparam int BUCKET_CAPACITY = 16;
  localparam int MAX_COLS        = 256;
  localparam int MAX_ROWS        = 256;

  localparam int BLOCKS_ACROSS = (MAX_COLS + BLOCK_SIDE - 1) / BLOCK_SIDE;
  localparam int BLOCKS_DOWN   = (MAX_ROWS + BLOCK_SIDE - 1) / BLOCK_SIDE;
  localparam int BUCKET_COUNT  = BLOCKS_ACROSS * BLOCKS_DOWN;
  localparam int ENTRY_COUNT   = BUCKET_COUNT * BUCKET_CAPACITY;

  // Derived widths
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int OFF_W  = $clog2(BLOCK_SIDE);
  localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int IDX_W  = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
  localparam int FILL_W = $clog2(BUCKET_CAPACITY + 1);
  localparam int ENT_AW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  // Fixed field widths
  localparam int DIM_W  = 9;
  localparam int POS_W  = 16;
  localparam int VAL_W  = 16;
  localparam int CIDX_W = 2;

  // Register map
  localparam logic [CIDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    ACT_LOOKUP   = 2'd0,
    ACT_SET_RES  = 2'd1,
    ACT_SET_CITY = 2'd2,
    ACT_SET_FORT = 2'd3
  } action_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CITY = 2'd1;
  localparam logic [1:0] KIND_FORT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // One bucket slot
  typedef struct packed {
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
    logic [1:0]       kind;
    logic [VAL_W-1:0] build;
    logic [VAL_W-1:0] res;
  } entry_t;

endpackage

@@ src/bst_ram.sv @@
module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bucketed_sparse_tile_attribute_store.sv @@
// Sparse per-tile attribute store. Tiles are grouped into BLOCK_SIDE x BLOCK_SIDE
// blocks; each block owns a bucket of up to BUCKET_CAPACITY entries held in a
// single-port-write / registered-read entry RAM, with a second small RAM holding
// each bucket's fill count. One transaction is worked at a time: the fill count
// is read on acceptance, then the bucket's entries are read one per cycle until
// the tile's offset matches or the fill is exhausted, then the decide state
// updates the RAMs when a set is stored and loads the result register. The next
// transaction can be accepted in the cycle the result first shows; out-of-grid
// positions skip the entry RAM. The entry scan is the rate limiter: one entry
// RAM read per cycle. The result register is separate, so a waiting result does
// not hold off acceptance of the next transaction; that one waits in its
// decide state until the result is taken. After reset and after every write
// of grid_width or grid_height the fill RAM is cleared by a sweep over all
// BUCKET_COUNT buckets (1024 with the default geometry), during which no
// transaction is accepted; configuration writes are always taken.
`include "bucketed_sparse_tile_attribute_store_macros.svh"

module bucketed_sparse_tile_attribute_store
  import bst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  // request
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [POS_W-1:0]  in_col,
  input  logic [POS_W-1:0]  in_row,
  input  logic [VAL_W-1:0]  in_value,
  // result
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_found,
  output logic [1:0]        out_kind,
  output logic [VAL_W-1:0]  out_build_index,
  output logic [VAL_W-1:0]  out_resource_index
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FILLD  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [BKT_W-1:0] clr_r, clr_nxt;
  logic [DIM_W-1:0] grid_w_r, grid_w_nxt;
  logic [DIM_W-1:0] grid_h_r, grid_h_nxt;

  // transaction context
  action_t           action_r;
  logic [OFF_W-1:0]  ox_r, oy_r;
  logic [VAL_W-1:0]  value_r;
  logic              oob_r;
  logic [BKT_W-1:0]  bucket_r;

  // search state
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  entry_t            ent_r, ent_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_found_r, out_found_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [VAL_W-1:0]  out_build_r, out_build_nxt;
  logic [VAL_W-1:0]  out_res_r, out_res_nxt;

  // request decode
  logic              in_acc;
  logic [POS_W-1:0]  eff_w, eff_h;
  logic              in_oob;
  logic [COL_W-1:0]  col_t;
  logic [ROW_W-1:0]  row_t;
  logic [BKT_W+ROW_W-1:0] bkt_wide;
  logic [BKT_W-1:0]  in_bucket;
  logic [OFF_W-1:0]  in_ox, in_oy;

  // RAM ports
  logic              fill_we, fill_re;
  logic [BKT_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata, fill_rdata;
  logic              ent_we, ent_re;
  logic [ENT_AW-1:0] ent_waddr, ent_raddr, ent_base;
  entry_t            ent_wdata, ent_rdata, ent_old;

  logic [IDX_W-1:0]  idx_inc;
  logic              scan_match, scan_last;
  logic              out_free, is_lookup, bucket_full, do_write;
  logic              cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ((cfg_index == REG_GRID_WIDTH) ||
                                   (cfg_index == REG_GRID_HEIGHT));

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Dimensions above the maximum act as the maximum; zero puts everything outside.
  assign eff_w  = (grid_w_r > MAX_COLS) ? POS_W'(MAX_COLS) : POS_W'(grid_w_r);
  assign eff_h  = (grid_h_r > MAX_ROWS) ? POS_W'(MAX_ROWS) : POS_W'(grid_h_r);
  assign in_oob = (in_col >= eff_w) || (in_row >= eff_h);

  // Only meaningful when inside the grid, where the narrow slices are exact.
  assign col_t     = in_col[COL_W-1:0];
  assign row_t     = in_row[ROW_W-1:0];
  assign bkt_wide  = (BKT_W+ROW_W)'(row_t / BLOCK_SIDE) * (BKT_W+ROW_W)'(BLOCKS_ACROSS)
                   + (BKT_W+ROW_W)'(col_t / BLOCK_SIDE);
  assign in_bucket = bkt_wide[BKT_W-1:0];
  assign in_ox     = OFF_W'(col_t % BLOCK_SIDE);
  assign in_oy     = OFF_W'(row_t % BLOCK_SIDE);

  // Fill count is fetched in the accept cycle.
  assign fill_re = in_acc;

  // Entry scan: FILLD issues slot 0, each SCAN cycle checks one slot and issues the next.
  assign ent_base   = ENT_AW'(bucket_r) * ENT_AW'(BUCKET_CAPACITY);
  assign idx_inc    = idx_r + 1'b1;
  assign ent_raddr  = (state_r == S_FILLD) ? ent_base : ent_base + ENT_AW'(idx_inc);
  assign scan_match = (ent_rdata.off_x == ox_r) && (ent_rdata.off_y == oy_r);
  assign scan_last  = (FILL_W'(idx_r) + FILL_W'(1)) == fill_r;
  assign ent_re     = ((state_r == S_FILLD) && (fill_rdata != '0)) ||
                      ((state_r == S_SCAN) && !scan_match && !scan_last);

  // Decide
  assign out_free    = !out_valid_r || !out_stall;
  assign is_lookup   = (action_r == ACT_LOOKUP);
  assign bucket_full = (fill_r == FILL_W'(BUCKET_CAPACITY));
  assign do_write    = (state_r == S_DECIDE) && out_free && !oob_r && !is_lookup &&
                       (hit_r || !bucket_full);

  always_comb begin
    if (hit_r) begin
      ent_old = ent_r;
    end else begin
      ent_old.off_x = ox_r;
      ent_old.off_y = oy_r;
      ent_old.kind  = KIND_NONE;
      ent_old.build = '0;
      ent_old.res   = '0;
    end
    ent_wdata = ent_old;
    if (action_r == ACT_SET_RES) begin
      ent_wdata.res = value_r;
    end else begin
      ent_wdata.kind  = (action_r == ACT_SET_CITY) ? KIND_CITY : KIND_FORT;
      ent_wdata.build = value_r;
    end
  end

  assign ent_we    = do_write;
  assign ent_waddr = ent_base + ENT_AW'(hit_r ? idx_r : fill_r[IDX_W-1:0]);

  // Fill RAM write: clearing sweep, or append of a new slot.
  assign fill_we    = (state_r == S_CLEAR) || (do_write && !hit_r);
  assign fill_waddr = (state_r == S_CLEAR) ? clr_r : bucket_r;
  assign fill_wdata = (state_r == S_CLEAR) ? '0 : fill_r + FILL_W'(1);

  bst_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKET_COUNT)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (in_bucket),
    .rdata (fill_rdata)
  );

  bst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Control and search sequencing
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    grid_w_nxt = grid_w_r;
    grid_h_nxt = grid_h_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    ent_nxt    = ent_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_W'(BUCKET_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_oob ? S_DECIDE : S_FILLD;
        end
      end
      S_FILLD: begin
        fill_nxt  = fill_rdata;
        idx_nxt   = '0;
        hit_nxt   = 1'b0;
        state_nxt = (fill_rdata == '0) ? S_DECIDE : S_SCAN;
      end
      S_SCAN: begin
        if (scan_match) begin
          hit_nxt   = 1'b1;
          ent_nxt   = ent_rdata;
          state_nxt = S_DECIDE;
        end else if (scan_last) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A dimension write restarts the clearing sweep.
    if (cfg_hit) begin
      state_nxt = S_CLEAR;
      clr_nxt   = '0;
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_w_nxt = cfg_data;
      end else begin
        grid_h_nxt = cfg_data;
      end
    end
  end

  // Result
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_kind_nxt   = out_kind_r;
    out_build_nxt  = out_build_r;
    out_res_nxt    = out_res_r;
    if ((state_r == S_DECIDE) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_found_nxt  = 1'b0;
      out_kind_nxt   = KIND_NONE;
      out_build_nxt  = '0;
      out_res_nxt    = '0;
      if (oob_r) begin
        // out-of-grid lookup reports plain none
        out_status_nxt = is_lookup ? ST_OK : ST_OOB;
      end else if (is_lookup) begin
        if (hit_r && ((ent_r.kind != KIND_NONE) || (ent_r.res != '0))) begin
          out_found_nxt = 1'b1;
          out_kind_nxt  = ent_r.kind;
          out_build_nxt = ent_r.build;
          out_res_nxt   = ent_r.res;
        end
      end else if (!hit_r && bucket_full) begin
        out_status_nxt = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      grid_w_r    <= DIM_W'(256);
      grid_h_r    <= DIM_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      grid_w_r    <= grid_w_nxt;
      grid_h_r    <= grid_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= action_t'(in_action);
      ox_r     <= in_ox;
      oy_r     <= in_oy;
      value_r  <= in_value;
      oob_r    <= in_oob;
      bucket_r <= in_bucket;
    end
    fill_r       <= fill_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    ent_r        <= ent_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_kind_r   <= out_kind_nxt;
    out_build_r  <= out_build_nxt;
    out_res_r    <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found          = out_found_r;
  assign out_kind           = out_kind_r;
  assign out_build_index    = out_build_r;
  assign out_resource_index = out_res_r;

  // Checks
  `BST_ASSERT_IMP(a_scan_within_fill, clk, rst_n, state_r == S_SCAN, FILL_W'(idx_r) < fill_r)
  `BST_ASSERT_IMP(a_write_only_set, clk, rst_n, ent_we, !oob_r && (action_r != ACT_LOOKUP))
  `BST_ASSERT_IMP(a_fill_bounded, clk, rst_n, fill_we, fill_wdata <= FILL_W'(BUCKET_CAPACITY))
  `BST_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

@@ verif/bucketed_sparse_tile_attribute_store_tb.sv @@
`timescale 1ns / 1ps

module bucketed_sparse_tile_attribute_store_tb;
  import bst_pkg::*;

  // Run limits. CYCLE_LIMIT leaves a wide margin over the slowest legal
  // transaction's scan, sender gap and receiver stall, plus the fill sweep
  // that each grid write adds.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int HOLD_AFTER   = 40;    // results checked before the hold-off starts
  localparam int DRAIN_CYCLES = 30;    // settle time after the last result
  localparam int PRINT_CAP    = 100;   // mismatch lines printed before going quiet

  // Register indexes with no register behind them
  localparam logic [CIDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    action_t          act;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [VAL_W-1:0] value;
  } tile_request_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [1:0]       kind;
    logic [VAL_W-1:0] build;
    logic [VAL_W-1:0] res;
  } tile_result_t;

  // DUT ports; every input starts at a known value
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_action = '0;
  logic [POS_W-1:0]  in_col = '0;
  logic [POS_W-1:0]  in_row = '0;
  logic [VAL_W-1:0]  in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic              out_found;
  logic [1:0]        out_kind;
  logic [VAL_W-1:0]  out_build_index;
  logic [VAL_W-1:0]  out_resource_index;

  bucketed_sparse_tile_attribute_store u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_col             (in_col),
    .in_row             (in_row),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_kind           (out_kind),
    .out_build_index    (out_build_index),
    .out_resource_index (out_resource_index)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the store: grid registers, tile marks, bucket fill counts
  // and bucket slots, kept in step with every accepted transaction.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] grid_w = 9'd256;
  logic [DIM_W-1:0] grid_h = 9'd256;
  bit               tile_marked  [MAX_COLS*MAX_ROWS];
  int               bucket_count [BUCKET_COUNT];
  entry_t           bucket_slots [ENTRY_COUNT];

  tile_request_t pending_requests[$];
  tile_result_t  expected_results[$];

  int  in_idle_max  = 12;
  int  out_idle_max = 12;
  bit  hold_go      = 1'b0;
  logic hold_off    = 1'b0;

  int  mismatches   = 0;
  int  n_issued     = 0;
  int  n_accepted   = 0;
  int  n_checked    = 0;
  int  n_oob_sets   = 0;
  int  n_full_sets  = 0;
  int  n_hits       = 0;
  int  n_settings   = 1;
  int  cycle_count  = 0;

  function automatic void wipe_tiles();
    foreach (tile_marked[i]) tile_marked[i] = 1'b0;
    foreach (bucket_count[i]) bucket_count[i] = 0;
  endfunction

  // Dimensions above the array size behave as the array size
  function automatic int clamp_dim(logic [DIM_W-1:0] dim, int limit);
    return (int'(dim) > limit) ? limit : int'(dim);
  endfunction

  // Work out the result of one transaction and update the shadow store.
  function automatic tile_result_t apply_tile_action(tile_request_t rq);
    tile_result_t     res;
    int               ew, eh, tile, bkt, slot, n, i;
    logic [OFF_W-1:0] ox, oy;
    entry_t           e;
    res = '0;
    ew  = clamp_dim(grid_w, MAX_COLS);
    eh  = clamp_dim(grid_h, MAX_ROWS);
    if (int'(rq.col) >= ew || int'(rq.row) >= eh) begin
      // lookups outside the grid quietly report nothing
      if (rq.act != ACT_LOOKUP) res.status = ST_OOB;
      return res;
    end
    tile = int'(rq.row) * MAX_COLS + int'(rq.col);
    bkt  = (int'(rq.row) / BLOCK_SIDE) * BLOCKS_ACROSS + int'(rq.col) / BLOCK_SIDE;
    ox   = OFF_W'(int'(rq.col) % BLOCK_SIDE);
    oy   = OFF_W'(int'(rq.row) % BLOCK_SIDE);
    slot = -1;
    for (i = 0; i < bucket_count[bkt]; i++) begin
      e = bucket_slots[bkt*BUCKET_CAPACITY + i];
      if (slot < 0 && e.off_x == ox && e.off_y == oy) slot = i;
    end

    if (rq.act == ACT_LOOKUP) begin
      if (tile_marked[tile] && slot >= 0) begin
        e = bucket_slots[bkt*BUCKET_CAPACITY + slot];
        // an entry with no kind and a zero resource reads as empty
        if (e.kind != KIND_NONE || e.res != '0) begin
          res.found = 1'b1;
          res.kind  = e.kind;
          res.build = e.build;
          res.res   = e.res;
        end
      end
      return res;
    end

    if (slot < 0) begin
      n = bucket_count[bkt];
      if (n >= BUCKET_CAPACITY) begin
        res.status = ST_FULL;
        return res;
      end
      e.off_x = ox;
      e.off_y = oy;
      e.kind  = KIND_NONE;
      e.build = '0;
      e.res   = '0;
      slot = n;
      bucket_count[bkt] = n + 1;
    end else begin
      e = bucket_slots[bkt*BUCKET_CAPACITY + slot];
    end

    if (rq.act == ACT_SET_RES) begin
      e.res = rq.value;
    end else begin
      e.kind  = (rq.act == ACT_SET_CITY) ? KIND_CITY : KIND_FORT;
      e.build = rq.value;
    end
    bucket_slots[bkt*BUCKET_CAPACITY + slot] = e;
    tile_marked[tile] = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on result %0d: %s", $realtime, n_checked, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: pulls from pending_requests, waits a drawn number of
  // cycles between transactions, holds the payload while stalled. The
  // expectation is computed at the edge where the transaction is taken.
  // ---------------------------------------------------------------------------
  tile_request_t cur_request;
  int            gap_left = 0;

  always @(posedge clk) begin
    bit           offering;
    tile_result_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offering = in_valid;
      if (in_valid && !in_stall) begin
        want = apply_tile_action(cur_request);
        expected_results.push_back(want);
        n_accepted++;
        if (cur_request.act != ACT_LOOKUP && want.status == ST_OOB) n_oob_sets++;
        if (want.status == ST_FULL) n_full_sets++;
        if (want.found) n_hits++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_request = pending_requests.pop_front();
          n_issued++;
          in_action <= cur_request.act;
          in_col    <= cur_request.col;
          in_row    <= cur_request.row;
          in_value  <= cur_request.value;
          in_valid  <= 1'b1;
          gap_left = $urandom_range(0, in_idle_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each taken result against the oldest expectation,
  // then stalls for a drawn number of cycles. hold_off stretches the stall.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    tile_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_found !== want.found)
            report_mismatch($sformatf("found %0d, want %0d", out_found, want.found));
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_build_index !== want.build)
            report_mismatch($sformatf("build_index %0h, want %0h",
                                      out_build_index, want.build));
          if (out_resource_index !== want.res)
            report_mismatch($sformatf("resource_index %0h, want %0h",
                                      out_resource_index, want.res));
        end
        n_checked++;
        stall_left = $urandom_range(0, out_idle_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // Long receiver hold-off, timed here so the sender keeps offering and the
  // block backs up into its input. Starts once results are flowing, well
  // past the clearing sweep after reset.
  initial begin
    wait (hold_go && n_checked >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_request(action_t act, int col, int row, int value);
    tile_request_t rq;
    rq.act   = act;
    rq.col   = POS_W'(col);
    rq.row   = POS_W'(row);
    rq.value = VAL_W'(value);
    pending_requests.push_back(rq);
  endtask

  // Register write; only issued with nothing in flight.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_WIDTH) begin
      grid_w = data;
      wipe_tiles();
    end else if (idx == REG_GRID_HEIGHT) begin
      grid_h = data;
      wipe_tiles();
    end
  endtask

  // Every transaction handed to the driver has had its result checked.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() > 0 || n_checked < n_issued ||
           expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Hand-picked transactions on the reset grid (256 x 256)
  task automatic queue_directed();
    int i;
    push_request(ACT_LOOKUP,   0,     0,     16'h5A5A); // empty store
    push_request(ACT_SET_RES,  0,     0,     16'hFFFF);
    push_request(ACT_LOOKUP,   0,     0,     0);
    push_request(ACT_SET_CITY, 255,   255,   16'hFFFF); // far corner
    push_request(ACT_SET_FORT, 255,   255,   0);        // kind overwritten
    push_request(ACT_LOOKUP,   255,   255,   0);
    push_request(ACT_SET_RES,  1,     0,     0);        // entry with nothing in it
    push_request(ACT_LOOKUP,   1,     0,     0);
    push_request(ACT_LOOKUP,   65535, 65535, 16'hFFFF); // lookup off the grid
    push_request(ACT_SET_CITY, 256,   0,     16'h0001); // set off the grid
    push_request(ACT_SET_FORT, 0,     256,   16'h8000);
    // fill bucket 0 to capacity (two entries already in it)
    for (i = 2; i < 16; i++)
      push_request(action_t'(1 + i % 3), i % BLOCK_SIDE, i / BLOCK_SIDE, i * 16'h1111);
    push_request(ACT_SET_RES,  0,     2,     16'h00FF); // new tile, bucket full
    push_request(ACT_SET_CITY, 1,     0,     16'h7777); // existing tile, still ok
    push_request(ACT_LOOKUP,   0,     2,     0);
  endtask

  // Random traffic: mostly sets and lookups clustered on three blocks so that
  // buckets fill and lookups hit, plus scattered in-grid and off-grid noise.
  task automatic queue_random(int count);
    int hot_bx [3];
    int hot_by [3];
    int ew, eh, h, pick, c, r, base, v;
    action_t act;
    ew = clamp_dim(grid_w, MAX_COLS);
    eh = clamp_dim(grid_h, MAX_ROWS);
    for (h = 0; h < 3; h++) begin
      hot_bx[h] = (ew > 0) ? $urandom_range(0, (ew - 1) / BLOCK_SIDE) : 0;
      hot_by[h] = (eh > 0) ? $urandom_range(0, (eh - 1) / BLOCK_SIDE) : 0;
    end
    repeat (count) begin
      pick = $urandom_range(0, 99);
      act  = ($urandom_range(0, 99) < 40) ? ACT_LOOKUP : action_t'($urandom_range(1, 3));
      if (ew == 0 || eh == 0 || pick < 8) begin
        if ($urandom_range(0, 1)) begin
          c = $urandom_range(ew, 65535);
          r = $urandom_range(0, 65535);
        end else begin
          c = $urandom_range(0, 65535);
          r = $urandom_range(eh, 65535);
        end
      end else if (pick < 20) begin
        c = $urandom_range(0, ew - 1);
        r = $urandom_range(0, eh - 1);
      end else begin
        h    = $urandom_range(0, 2);
        base = hot_bx[h] * BLOCK_SIDE;
        c    = $urandom_range(base, (base + BLOCK_SIDE - 1 < ew) ? base + BLOCK_SIDE - 1
                                                                 : ew - 1);
        base = hot_by[h] * BLOCK_SIDE;
        r    = $urandom_range(base, (base + BLOCK_SIDE - 1 < eh) ? base + BLOCK_SIDE - 1
                                                                 : eh - 1);
      end
      v = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 16'hFFFF);
      push_request(act, c, r, v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    wipe_tiles();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid, full idling, long receiver hold-off early on
    hold_go = 1'b1;
    queue_directed();
    queue_random(500);
    wait_idle();

    // smallest grid: one tile
    write_reg(REG_GRID_WIDTH, 9'd1);
    write_reg(REG_GRID_HEIGHT, 9'd1);
    n_settings++;
    queue_random(100);
    wait_idle();

    // oversize dimensions clamp to the array; back-to-back, no idling
    in_idle_max  = 0;
    out_idle_max = 0;
    write_reg(REG_GRID_WIDTH, 9'd511);
    write_reg(REG_GRID_HEIGHT, 9'd300);
    n_settings++;
    queue_random(350);
    wait_idle();

    // writes to spare indexes must leave the store alone
    in_idle_max  = 12;
    out_idle_max = 12;
    write_reg(REG_SPARE_2, 9'h155);
    write_reg(REG_SPARE_3, 9'h0AA);
    queue_random(60);
    wait_idle();

    // zero width: everything lands off the grid
    write_reg(REG_GRID_WIDTH, 9'd0);
    n_settings++;
    queue_random(50);
    wait_idle();

    // odd sizes with partial edge blocks
    write_reg(REG_GRID_WIDTH, 9'd37);
    write_reg(REG_GRID_HEIGHT, 9'd19);
    n_settings++;
    queue_random(400);
    wait_idle();

    // full grid again; fast sender, slow receiver
    in_idle_max = 0;
    write_reg(REG_GRID_WIDTH, 9'd256);
    write_reg(REG_GRID_HEIGHT, 9'd256);
    n_settings++;
    queue_random(190);
    wait_idle();

    $display("ran %0d transactions over %0d grid settings, %0d results checked",
             n_accepted, n_settings, n_checked);
    $display("%0d off-grid sets, %0d full-bucket sets, %0d lookup hits, %0d mismatches",
             n_oob_sets, n_full_sets, n_hits, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ bucketed_sparse_tile_attribute_store.f @@
+incdir+src
src/bst_pkg.sv
src/bst_ram.sv
src/bucketed_sparse_tile_attribute_store.sv
verif/bucketed_sparse_tile_attribute_store_tb.sv
